/* rtl/jpts_pkg.sv */
// Shared types, constants and helper functions for the joint PD tracking step.
// Used by joint_pd_tracking_step_unit; no other dependencies.
`timescale 1ns / 1ps
`default_nettype none
package jpts_pkg;

  localparam int JOINT_COUNT  = 7;
  localparam int JIDX_W       = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;
  localparam int CORDIC_STEPS = 24;
  localparam int RAM_W        = 48;

  localparam logic signed [33:0] CORDIC_GAIN  = 34'sd652032874;
  localparam logic signed [22:0] PI_Q20       = 23'sd3294199;
  localparam logic        [16:0] W_ONE        = 17'd65536;
  localparam logic        [16:0] FW_RESET     = 17'd65536;
  localparam logic        [22:0] LIMIT_RESET  = 23'd4096;
  localparam logic        [23:0] VEL_CLAMP    = 24'd8388608;

  // Register index taken from paddr[2]
  localparam logic REG_FILTER_WEIGHT = 1'b0;
  localparam logic REG_STEP_LIMIT    = 1'b1;

  typedef struct packed {
    logic        [2:0]  joint;
    logic               start_req;
    logic        [31:0] elapsed_time;
    logic signed [23:0] position;
    logic signed [23:0] velocity;
    logic signed [23:0] feedforward;
    logic signed [23:0] last_torque;
    logic        [19:0] stiffness_gain;
    logic        [19:0] damping_gain;
    logic signed [23:0] swing;
    logic        [23:0] period;
  } jpts_in_t;

  typedef struct packed {
    logic signed [23:0] torque_command;
    logic signed [23:0] reference_position;
    logic signed [23:0] reference_velocity;
  } jpts_out_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_READ,
    S_FILT_B,
    S_FILT_C,
    S_PDIV,
    S_CINIT,
    S_CORD,
    S_CMAP,
    S_QMUL,
    S_QD,
    S_P,
    S_NUM,
    S_VINIT,
    S_VDIV,
    S_VEL,
    S_T1,
    S_T2,
    S_DONE
  } jpts_state_e;

  // Arctangent of 2^-i in Q0.32 turns
  function automatic logic [29:0] atan_turns(input logic [4:0] i);
    logic [29:0] r;
    case (i)
      5'd0:    r = 30'd536870912;
      5'd1:    r = 30'd316933406;
      5'd2:    r = 30'd167458907;
      5'd3:    r = 30'd85004756;
      5'd4:    r = 30'd42667331;
      5'd5:    r = 30'd21354465;
      5'd6:    r = 30'd10679838;
      5'd7:    r = 30'd5340245;
      5'd8:    r = 30'd2670163;
      5'd9:    r = 30'd1335087;
      5'd10:   r = 30'd667544;
      5'd11:   r = 30'd333772;
      5'd12:   r = 30'd166886;
      5'd13:   r = 30'd83443;
      5'd14:   r = 30'd41722;
      5'd15:   r = 30'd20861;
      5'd16:   r = 30'd10430;
      5'd17:   r = 30'd5215;
      5'd18:   r = 30'd2608;
      5'd19:   r = 30'd1304;
      5'd20:   r = 30'd652;
      5'd21:   r = 30'd326;
      5'd22:   r = 30'd163;
      5'd23:   r = 30'd81;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
    logic signed [23:0] r;
    if (v > 64'sd8388607) begin
      r = 24'sh7FFFFF;
    end else if (v < -64'sd8388608) begin
      r = 24'sh800000;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* rtl/jpts_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module jpts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire logic                             clk_i,
  input  wire logic                             we_i,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                 wdata_i,
  input  wire logic                             re_i,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

/* rtl/joint_pd_tracking_step_unit.sv */
// Joint PD tracking step: cosine reference, velocity filter, PD law, torque rate limit.
// Depends on jpts_pkg and jpts_ram.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_word_i) carries one joint sample per
//   word. Output channel (out_valid_o / out_stall_i / out_word_o) returns one result
//   word per sample, in order. Configuration goes through the APB port: filter weight
//   at byte address 0, torque step limit at byte address 4; pready is always high.
//   Write configuration only while the block is idle.
//   The work runs through the 64-step shared restoring divider (phase), the 24
//   CORDIC iterations and the 24-step divider pass (reference velocity). One sample
//   is in work at a time; the next is taken the cycle after a result moves into the
//   output register.
//   Per-joint state (start position, filtered velocity) lives in a small RAM; valid
//   bits cleared by reset make never-written joints read as zero, so no clearing
//   pass is needed. Reset is asynchronous, active low.
//   A stalled output word holds in its register; the finished next result waits in
//   the last state until the output register frees up.
`timescale 1ns / 1ps
`default_nettype none
module joint_pd_tracking_step_unit
  import jpts_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire jpts_in_t    in_word_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output jpts_out_t        out_word_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  jpts_state_e state_q, state_d;

  // configuration
  logic [16:0] fw_q;
  logic [22:0] lim_q;
  logic        cfg_wr;
  logic [16:0] w_eff;

  // latched word and derived controls
  jpts_in_t    in_q;
  logic [23:0] per_q;
  logic        use_q;
  logic        accept;
  logic        jvalid_in;
  logic        jvalid_q;
  logic [JOINT_COUNT-1:0] vld_q;

  // state RAM
  logic              ram_we;
  logic [JIDX_W-1:0] ram_waddr;
  logic [JIDX_W-1:0] ram_raddr;
  logic [RAM_W-1:0]  ram_wdata;
  logic [RAM_W-1:0]  ram_rdata;

  // shared multiplier
  logic signed [24:0] mul_a;
  logic signed [34:0] mul_b;
  logic signed [59:0] prod_q;
  logic signed [47:0] acc_q;

  // filter
  logic signed [23:0] st_q;
  logic signed [23:0] st_sel;
  logic signed [23:0] fv_sel;
  logic signed [23:0] fvn_q;
  logic signed [59:0] filt_sum;
  logic signed [59:0] filt_rnd;

  // divider
  logic [23:0] div_r_q;
  logic [63:0] div_src_q;
  logic [31:0] div_q_q;
  logic [6:0]  cnt_q;
  logic [24:0] div_rsh;
  logic        div_ge;
  logic [24:0] div_sub;

  // CORDIC
  logic signed [33:0] cx_q, cy_q, cz_q;
  logic signed [33:0] cdx, cdy, cat;
  logic [1:0]         quad_q;
  logic [31:0]        turns_rot;
  logic [1:0]         quad_in;
  logic [31:0]        z_in;
  logic signed [33:0] cos_q, sin_q;

  // reference and torque
  logic signed [23:0] qd_q;
  logic signed [59:0] qd_rnd;
  logic signed [30:0] qd_sum;
  logic signed [59:0] p_rnd;
  logic signed [41:0] p_q;
  logic signed [63:0] num_q;
  logic [63:0]        mag;
  logic [63:0]        nsum;
  logic [43:0]        nq;
  logic               vsat_q;
  logic [23:0]        qv;
  logic signed [24:0] dqd_w;
  logic signed [23:0] dqd_q;
  logic signed [59:0] t_rnd;
  logic signed [47:0] tau;
  logic signed [47:0] diff;
  logic signed [47:0] lim_s;
  logic signed [47:0] diff_c;
  jpts_out_t          res_q;
  jpts_out_t          res_d;
  jpts_out_t          out_q;
  logic               out_valid_q;
  logic               out_load;

  // ---------------------------------------------------------------- config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_STEP_LIMIT) ? {9'd0, lim_q} : {15'd0, fw_q};
  assign w_eff  = (fw_q > W_ONE) ? W_ONE : fw_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q  <= FW_RESET;
      lim_q <= LIMIT_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_FILTER_WEIGHT) begin
        fw_q <= pwdata[16:0];
      end else begin
        lim_q <= pwdata[22:0];
      end
    end
  end

  // ---------------------------------------------------------------- handshakes
  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;
  assign jvalid_in   = (int'(in_word_i.joint) < JOINT_COUNT);

  // ---------------------------------------------------------------- state RAM
  assign ram_raddr = JIDX_W'(in_word_i.joint);
  assign ram_waddr = JIDX_W'(in_q.joint);
  assign ram_we    = (state_q == S_FILT_C) && jvalid_q;
  assign ram_wdata = {st_q, filt_rnd[23:0]};

  jpts_ram #(
    .WIDTH(RAM_W),
    .DEPTH(JOINT_COUNT)
  ) u_state_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (accept),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Valid bits: a joint never written reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (ram_we) begin
      vld_q[ram_waddr] <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- combinational datapath
  assign fv_sel = use_q ? ram_rdata[23:0] : 24'sd0;
  assign st_sel = in_q.start_req ? in_q.position : (use_q ? ram_rdata[47:24] : 24'sd0);

  assign filt_sum = 60'(acc_q) + prod_q;
  assign filt_rnd = (filt_sum + 60'sd32768) >>> 16;

  // One restoring division step: bring in the next dividend bit
  assign div_rsh = {div_r_q, div_src_q[63]};
  assign div_ge  = (div_rsh >= {1'b0, per_q});
  assign div_sub = div_rsh - {1'b0, per_q};

  // CORDIC step, index from the counter
  assign cdx = cy_q >>> cnt_q[4:0];
  assign cdy = cx_q >>> cnt_q[4:0];
  assign cat = 34'(atan_turns(cnt_q[4:0]));

  // Nearest quarter turn, residual angle wraps to signed
  assign turns_rot = div_q_q + 32'h2000_0000;
  assign quad_in   = turns_rot[31:30];
  assign z_in      = div_q_q - {quad_in, 30'd0};

  assign qd_rnd = (prod_q + 60'sh4000_0000) >>> 31;
  assign qd_sum = 31'(st_q) + qd_rnd[30:0];
  assign p_rnd  = (prod_q + 60'sd8192) >>> 14;

  assign mag  = num_q[63] ? 64'(-num_q) : 64'(num_q);
  assign nsum = mag + {21'd0, per_q, 19'd0};
  assign nq   = nsum[63:20];

  assign qv = vsat_q ? VEL_CLAMP
            : ((div_q_q[23:0] > VEL_CLAMP) ? VEL_CLAMP : div_q_q[23:0]);
  assign dqd_w = num_q[63] ? -$signed({1'b0, qv}) : $signed({1'b0, qv});

  assign t_rnd  = (prod_q + 60'sd128) >>> 8;
  assign tau    = 48'(in_q.feedforward) + acc_q + t_rnd[47:0];
  assign diff   = tau - 48'(in_q.last_torque);
  assign lim_s  = $signed({25'd0, lim_q});
  assign diff_c = (diff > lim_s) ? lim_s : ((diff < -lim_s) ? -lim_s : diff);

  always_comb begin
    res_d                    = res_q;
    res_d.torque_command     = sat24(64'(48'(in_q.last_torque) + diff_c));
    res_d.reference_position = qd_q;
    res_d.reference_velocity = dqd_q;
  end

  // Operand select for the shared multiplier
  always_comb begin
    case (state_q)
      S_READ: begin
        mul_a = $signed({8'd0, W_ONE - w_eff});
        mul_b = 35'(fv_sel);
      end
      S_FILT_B: begin
        mul_a = $signed({8'd0, w_eff});
        mul_b = 35'(in_q.velocity);
      end
      S_QMUL: begin
        mul_a = 25'(in_q.swing);
        mul_b = 35'sd1073741824 - 35'(cos_q);
      end
      S_QD: begin
        mul_a = 25'(in_q.swing);
        mul_b = 35'(sin_q);
      end
      S_VEL: begin
        mul_a = $signed({5'd0, in_q.stiffness_gain});
        mul_b = 35'(25'(qd_q) - 25'(in_q.position));
      end
      S_T1: begin
        mul_a = $signed({5'd0, in_q.damping_gain});
        mul_b = 35'(25'(dqd_q) - 25'(fvn_q));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    out_load = 1'b0;
    case (state_q)
      S_IDLE:   if (accept) state_d = S_READ;
      S_READ:   state_d = S_FILT_B;
      S_FILT_B: state_d = S_FILT_C;
      S_FILT_C: state_d = S_PDIV;
      S_PDIV:   if (cnt_q == 7'd1) state_d = S_CINIT;
      S_CINIT:  state_d = S_CORD;
      S_CORD:   if (cnt_q == 7'(CORDIC_STEPS - 1)) state_d = S_CMAP;
      S_CMAP:   state_d = S_QMUL;
      S_QMUL:   state_d = S_QD;
      S_QD:     state_d = S_P;
      S_P:      state_d = S_NUM;
      S_NUM:    state_d = S_VINIT;
      S_VINIT:  state_d = S_VDIV;
      S_VDIV:   if (cnt_q == 7'd1) state_d = S_VEL;
      S_VEL:    state_d = S_T1;
      S_T1:     state_d = S_T2;
      S_T2:     state_d = S_DONE;
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default:  state_d = S_IDLE;
    endcase
  end

  // Output register: hold while stalled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= res_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      case (state_q)
        S_FILT_C: cnt_q <= 7'd64;
        S_PDIV:   cnt_q <= cnt_q - 7'd1;
        S_CINIT:  cnt_q <= '0;
        S_CORD:   cnt_q <= cnt_q + 7'd1;
        S_VINIT:  cnt_q <= 7'd24;
        S_VDIV:   cnt_q <= cnt_q - 7'd1;
        default:  cnt_q <= cnt_q;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          in_q     <= in_word_i;
          per_q    <= (in_word_i.period == 24'd0) ? 24'd1 : in_word_i.period;
          jvalid_q <= jvalid_in;
          use_q    <= jvalid_in && vld_q[ram_raddr];
        end
      end
      S_READ: begin
        st_q <= st_sel;
      end
      S_FILT_B: begin
        acc_q <= prod_q[47:0];
      end
      S_FILT_C: begin
        fvn_q     <= filt_rnd[23:0];
        div_r_q   <= '0;
        div_src_q <= {in_q.elapsed_time, 32'd0};
      end
      S_PDIV, S_VDIV: begin
        div_r_q   <= div_ge ? div_sub[23:0] : div_rsh[23:0];
        div_src_q <= {div_src_q[62:0], 1'b0};
        div_q_q   <= {div_q_q[30:0], div_ge};
      end
      S_CINIT: begin
        quad_q <= quad_in;
        cx_q   <= CORDIC_GAIN;
        cy_q   <= '0;
        cz_q   <= 34'($signed(z_in));
      end
      S_CORD: begin
        if (!cz_q[33]) begin
          cx_q <= cx_q - cdx;
          cy_q <= cy_q + cdy;
          cz_q <= cz_q - cat;
        end else begin
          cx_q <= cx_q + cdx;
          cy_q <= cy_q - cdy;
          cz_q <= cz_q + cat;
        end
      end
      S_CMAP: begin
        case (quad_q)
          2'd0: begin cos_q <= cx_q;  sin_q <= cy_q;  end
          2'd1: begin cos_q <= -cy_q; sin_q <= cx_q;  end
          2'd2: begin cos_q <= -cx_q; sin_q <= -cy_q; end
          default: begin cos_q <= cy_q; sin_q <= -cx_q; end
        endcase
      end
      S_QD: begin
        qd_q <= sat24(64'(qd_sum));
      end
      S_P: begin
        p_q <= p_rnd[41:0];
      end
      S_NUM: begin
        num_q <= 64'(p_q) * 64'(PI_Q20);
      end
      S_VINIT: begin
        vsat_q    <= ({4'd0, nq[43:24]} >= per_q);
        div_r_q   <= {4'd0, nq[43:24]};
        div_src_q <= {nq[23:0], 40'd0};
      end
      S_VEL: begin
        dqd_q <= sat24(64'(dqd_w));
      end
      S_T1: begin
        acc_q <= t_rnd[47:0];
      end
      S_T2: begin
        res_q <= res_d;
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------- assertions
  // Busy means the input side is held off
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> in_stall_o)
    else $error("input taken while a word is in work");

  // A new result only comes out of the final state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result raised outside the final state");

  // A state write marks its joint as valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> vld_q[$past(ram_waddr)])
    else $error("written joint not marked valid");

endmodule
`default_nettype wire

/* tb/testbench.sv */
// Self-checking bench for joint_pd_tracking_step_unit: drives joint samples,
// predicts each result word in place and compares it with the block's output.
// Depends on jpts_pkg for the word types and register indexes.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
  import jpts_pkg::*;

  localparam int SETTLE_CYCLES = 150;

  // CORDIC arctangent steps in Q0.32 turns
  localparam longint ATAN_Q32 [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  jpts_in_t    in_word_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  jpts_out_t   out_word_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  joint_pd_tracking_step_unit dut (.*);

  // Predictor copy of the registers and per-joint state
  longint    cur_weight;
  longint    cur_step_limit;
  longint    start_pos [JOINT_COUNT];
  longint    vel_filt  [JOINT_COUNT];
  jpts_out_t pending_cmds [$];
  int        mismatches = 0;
  int        hold_cycles = 0;    // long receiver hold-off, counted below
  int        out_gap = 0;        // stall cycles drawn for the next word
  bit        rx_quiet = 1'b0;    // receiver draws no stall gap while set
  bit        tx_quiet = 1'b0;    // sender never idles while set

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic longint round_q(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp24(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  // Cosine and sine in Q2.30 of an angle in Q0.32 turns
  task automatic cordic_turns(input logic [31:0] turns, output longint c, output longint s);
    logic [31:0] shifted;
    logic [1:0]  quad;
    longint      x, y, z, dx, dy;
    shifted = turns + 32'h2000_0000;
    quad = shifted[31:30];
    z = longint'(turns) - longint'(quad) * 64'sh4000_0000;
    if (z >= 64'sh8000_0000) z -= 64'sh1_0000_0000;
    x = 652032874;
    y = 0;
    for (int i = 0; i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_Q32[i];
      end else begin
        x += dx; y -= dy; z += ATAN_Q32[i];
      end
    end
    case (quad)
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endtask

  // Work out the result word of one sample and advance the joint state
  task automatic compute_tracking_step(input jpts_in_t w, output jpts_out_t r);
    bit              known;
    longint          pos, vel, ff, last, kp, kd, swing, st, fv, wt, c, s;
    longint          qd, dqd, p, num, tau, diff;
    longint unsigned per, mag, den, q, phase;
    known = w.joint < JOINT_COUNT;
    pos = longint'(w.position);
    vel = longint'(w.velocity);
    ff = longint'(w.feedforward);
    last = longint'(w.last_torque);
    swing = longint'(w.swing);
    kp = longint'(w.stiffness_gain);
    kd = longint'(w.damping_gain);
    st = known ? start_pos[w.joint] : 0;
    fv = known ? vel_filt[w.joint] : 0;
    wt = (cur_weight > 65536) ? 65536 : cur_weight;
    if (w.start_req) st = pos;
    fv = round_q((65536 - wt) * fv + wt * vel, 16);
    if (known) begin
      start_pos[w.joint] = st;
      vel_filt[w.joint] = fv;
    end
    per = (w.period == '0) ? 64'd1 : 64'(w.period);
    phase = ((longint'(w.elapsed_time) % per) << 32) / per;
    cordic_turns(phase[31:0], c, s);
    qd = clamp24(st + round_q(swing * ((64'sd1 <<< 30) - c), 31));
    p = round_q(swing * s, 14);
    num = p * 3294199;
    den = per << 20;
    mag = (num < 0) ? -num : num;
    q = (mag + den / 2) / den;
    if (q > 8388608) q = 8388608;
    dqd = clamp24((num < 0) ? -longint'(q) : longint'(q));
    tau = ff + round_q(kp * (qd - pos), 8) + round_q(kd * (dqd - fv), 8);
    diff = tau - last;
    if (diff > cur_step_limit) diff = cur_step_limit;
    if (diff < -cur_step_limit) diff = -cur_step_limit;
    r.torque_command = 24'(clamp24(last + diff));
    r.reference_position = 24'(qd);
    r.reference_velocity = 24'(dqd);
  endtask

  task automatic report(input string what, input longint got, input longint want);
    mismatches++;
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
  endtask

  // Compare each accepted result word with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_cmds.size() == 0) begin
        report("unexpected word", 0, 0);
      end else begin
        automatic jpts_out_t e = pending_cmds.pop_front();
        if (out_word_o.torque_command !== e.torque_command)
          report("torque_command", longint'(out_word_o.torque_command),
                 longint'(e.torque_command));
        if (out_word_o.reference_position !== e.reference_position)
          report("reference_position", longint'(out_word_o.reference_position),
                 longint'(e.reference_position));
        if (out_word_o.reference_velocity !== e.reference_velocity)
          report("reference_velocity", longint'(out_word_o.reference_velocity),
                 longint'(e.reference_velocity));
      end
      out_gap = rx_quiet ? 0 : $urandom_range(0, 3);
    end
  end

  // Receiver: a long hold-off wins, else stall the next word for the drawn gap
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        out_stall_i <= 1'b1;
        hold_cycles--;
      end else if (out_gap > 0 && !rx_quiet && out_valid_o) begin
        out_stall_i <= 1'b1;
        out_gap--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Offer one sample after a random gap (none while tx_quiet), hold it until accepted, then predict
  task automatic send_sample(input jpts_in_t w);
    jpts_out_t r;
    int        gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 3);
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_word_i <= w;
    do @(posedge clk_i); while (in_stall_o);
    compute_tracking_step(w, r);
    pending_cmds = {pending_cmds, r};
  endtask

  task automatic drop_valid();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic wait_idle();
    drop_valid();
    wait (pending_cmds.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // APB write: setup, then access; lands at the edge with penable high
  task automatic write_reg(input logic idx, input logic [31:0] value);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_FILTER_WEIGHT) cur_weight = longint'(value[16:0]);
    else cur_step_limit = longint'(value[22:0]);
  endtask

  function automatic jpts_in_t any_sample();
    jpts_in_t w;
    w.joint = 3'($urandom_range(0, 7));
    w.start_req = 1'($urandom_range(0, 1));
    w.elapsed_time = $urandom;
    w.position = 24'($urandom);
    w.velocity = 24'($urandom);
    w.feedforward = 24'($urandom);
    w.last_torque = 24'($urandom);
    w.stiffness_gain = 20'($urandom);
    w.damping_gain = 20'($urandom);
    w.swing = 24'($urandom);
    w.period = 24'($urandom);
    return w;
  endfunction

  // Sane sample around a joint's trajectory: moderate gains and signals
  function automatic jpts_in_t tracking_sample(int j, logic [31:0] t, logic [23:0] per);
    jpts_in_t w;
    w = any_sample();
    w.joint = 3'(j);
    w.start_req = 1'b0;
    w.elapsed_time = t;
    w.period = per;
    w.position = 24'($signed($urandom_range(0, 16383)) - 8192);
    w.velocity = 24'($signed($urandom_range(0, 32767)) - 16384);
    w.feedforward = 24'($signed($urandom_range(0, 8191)) - 4096);
    w.last_torque = 24'($signed($urandom_range(0, 65535)) - 32768);
    w.stiffness_gain = 20'($urandom_range(0, 1 << 14));
    w.damping_gain = 20'($urandom_range(0, 1 << 12));
    w.swing = 24'($signed($urandom_range(0, 8191)) - 4096);
    return w;
  endfunction

  task automatic test_directed();
    jpts_in_t w;
    w = tracking_sample(0, 32'd0, 24'h10000);
    w.start_req = 1'b1;
    send_sample(w);
    send_sample(tracking_sample(0, 32'h4000, 24'h10000));
    // out-of-range joint: no state touched, with and without start
    w = any_sample(); w.joint = 3'd7; w.start_req = 1'b0; send_sample(w);
    w = any_sample(); w.joint = 3'd7; w.start_req = 1'b1; send_sample(w);
    // zero period counts as one LSB
    w = tracking_sample(1, 32'h1234_5678, 24'd0); send_sample(w);
    w = tracking_sample(1, 32'hFFFF_FFFF, 24'hFF_FFFF); send_sample(w);
    w = tracking_sample(2, 32'd0, 24'd1); w.start_req = 1'b1; send_sample(w);
    // field extremes, pushing outputs toward saturation
    w = any_sample(); w.joint = 3'd3; w.start_req = 1'b1;
    w.position = 24'h7F_FFFF; w.swing = 24'h7F_FFFF; w.period = 24'd3;
    w.elapsed_time = 32'd1; w.stiffness_gain = 20'hF_FFFF; w.damping_gain = 20'hF_FFFF;
    w.feedforward = 24'h7F_FFFF; w.last_torque = 24'h7F_FFFF; send_sample(w);
    w.position = 24'h80_0000; w.swing = 24'h80_0000; w.feedforward = 24'h80_0000;
    w.last_torque = 24'h80_0000; w.velocity = 24'h80_0000; w.elapsed_time = 32'd2;
    send_sample(w);
    w.velocity = 24'h7F_FFFF; w.start_req = 1'b0; w.elapsed_time = 32'hFFFF_FFFF;
    w.period = 24'hFF_FFFF; send_sample(w);
    w = tracking_sample(4, 32'd0, 24'd4); w.stiffness_gain = '0; w.damping_gain = '0;
    w.swing = '0; send_sample(w);
    for (int i = 0; i < 8; i++) begin
      w = tracking_sample(5, 32'h4000 * i, 24'h2_0000);
      w.start_req = (i == 0);
      send_sample(w);
    end
    for (int j = 0; j < JOINT_COUNT; j++) send_sample(tracking_sample(j, 32'h100, 24'h8000));
    wait_idle();
  endtask

  task automatic test_config_sweep();
    logic [31:0] weights [4];
    logic [31:0] limits [4];
    weights = '{32'd0, 32'd65536, 32'd131071, 32'd16384};
    limits = '{32'd0, 32'd8388607, 32'd1, 32'd4096};
    for (int k = 0; k < 4; k++) begin
      write_reg(REG_FILTER_WEIGHT, weights[k]);
      write_reg(REG_STEP_LIMIT, limits[k]);
      for (int i = 0; i < 12; i++)
        send_sample(tracking_sample($urandom_range(0, 6), 32'h800 * i, 24'h1_0000));
      send_sample(any_sample());
      wait_idle();
    end
  endtask

  // Mostly trajectories (start, then rising times) per joint; some noise
  task automatic test_random(input int count);
    jpts_in_t    w;
    int          sent, j, len;
    logic [31:0] t;
    logic [23:0] per;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 9) < 2) begin
        send_sample(any_sample());
        sent++;
      end else begin
        j = $urandom_range(0, 6);
        per = ($urandom_range(0, 7) == 0) ? 24'($urandom) : 24'($urandom_range(256, 1 << 20));
        t = $urandom_range(0, 1 << 20);
        len = $urandom_range(3, 12);
        for (int i = 0; i < len; i++) begin
          w = tracking_sample(j, t, per);
          w.start_req = (i == 0);
          send_sample(w);
          t += $urandom_range(1, 1 << 14);
          sent++;
        end
      end
      // stretches with no idling on one side or both
      rx_quiet = ($urandom_range(0, 5) == 0);
      tx_quiet = ($urandom_range(0, 5) == 0);
    end
    rx_quiet = 1'b0;
    tx_quiet = 1'b0;
    wait_idle();
  endtask

  // Hold the receiver off long enough that the block stalls its input
  task automatic test_backpressure();
    hold_cycles = 600;
    for (int i = 0; i < 6; i++)
      send_sample(tracking_sample($urandom_range(0, 6), 32'h400 * i, 24'h4000));
    wait_idle();
  endtask

  initial begin
    cur_weight = longint'(FW_RESET);
    cur_step_limit = longint'(LIMIT_RESET);
    foreach (start_pos[i]) begin
      start_pos[i] = 0;
      vel_filt[i] = 0;
    end
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_config_sweep();
    write_reg(REG_FILTER_WEIGHT, 32'd40000);
    write_reg(REG_STEP_LIMIT, 32'd20000);
    test_random(440);
    test_backpressure();
    write_reg(REG_FILTER_WEIGHT, 32'($urandom_range(0, 65536)));
    write_reg(REG_STEP_LIMIT, 32'($urandom_range(0, 8388607)));
    test_random(400);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* filelist.f */
rtl/jpts_pkg.sv
rtl/jpts_ram.sv
rtl/joint_pd_tracking_step_unit.sv
tb/testbench.sv
